// File: src/assert_macros.svh
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: src/svpwm_pkg.sv
`timescale 1ns / 1ps
package svpwm_pkg;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int VOLT_BITS_DEF  = 16;
	localparam int PH_BITS        = 20;
	localparam int CORDIC_STEPS   = 16;
	localparam logic [15:0] PERIOD_RESET = 16'd4000;
	localparam int K_INV          = 19898;
	localparam int Q16_SQRT3      = 113512;
	localparam int Q16_HALF_SQRT3 = 56756;
	localparam int Q16_THREE_HALF = 98304;

	function automatic logic signed [21:0] atan_lut(input logic [3:0] i);
		logic signed [21:0] r;
		begin
			unique case (i)
				4'd0:  r = 22'sd131072;
				4'd1:  r = 22'sd77376;
				4'd2:  r = 22'sd40884;
				4'd3:  r = 22'sd20753;
				4'd4:  r = 22'sd10417;
				4'd5:  r = 22'sd5213;
				4'd6:  r = 22'sd2607;
				4'd7:  r = 22'sd1304;
				4'd8:  r = 22'sd652;
				4'd9:  r = 22'sd326;
				4'd10: r = 22'sd163;
				4'd11: r = 22'sd81;
				4'd12: r = 22'sd41;
				4'd13: r = 22'sd20;
				4'd14: r = 22'sd10;
				default: r = 22'sd5;
			endcase
			return r;
		end
	endfunction
endpackage

// File: src/svpwm_if.sv
`timescale 1ns / 1ps
interface svpwm_in_if #(parameter int VOLT_BITS = 16, parameter int ANGLE_BITS = 16);
	logic valid;
	logic ready;
	logic signed [VOLT_BITS-1:0] vd_voltage;
	logic signed [VOLT_BITS-1:0] vq_voltage;
	logic [ANGLE_BITS-1:0] rotor_angle;
	logic [VOLT_BITS-1:0] bus_voltage;
	modport source (output valid, vd_voltage, vq_voltage, rotor_angle, bus_voltage,
		input ready);
	modport sink (input valid, vd_voltage, vq_voltage, rotor_angle, bus_voltage,
		output ready);
endinterface

interface svpwm_out_if;
	logic valid;
	logic ready;
	logic [14:0] ccr_a;
	logic [14:0] ccr_b;
	logic [14:0] ccr_c;
	logic [2:0] sector;
	logic overmodulated;
	modport source (output valid, ccr_a, ccr_b, ccr_c, sector, overmodulated,
		input ready);
	modport sink (input valid, ccr_a, ccr_b, ccr_c, sector, overmodulated,
		output ready);
endinterface

// File: src/svpwm_cordic_cell.sv
`timescale 1ns / 1ps
// One CORDIC rotation; the item's other payload rides along.
module svpwm_cordic_cell #(
	parameter int STEP = 0,
	parameter int PW = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  logic signed [17:0] x_in,
	input  logic signed [17:0] y_in,
	input  logic signed [21:0] z_in,
	input  logic [PW-1:0] pl_in,
	output logic vld_q,
	output logic signed [17:0] x_q,
	output logic signed [17:0] y_q,
	output logic signed [21:0] z_q,
	output logic [PW-1:0] pl_q
);
	import svpwm_pkg::*;
	logic signed [17:0] dx, dy;
	logic signed [21:0] at;
	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;
	assign at = atan_lut(4'(STEP));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= vld_in;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pl_q <= pl_in;
			if (!z_in[21]) begin
				x_q <= x_in - dx; y_q <= y_in + dy; z_q <= z_in - at;
			end else begin
				x_q <= x_in + dx; y_q <= y_in - dy; z_q <= z_in + at;
			end
		end
	end
endmodule

// File: src/svpwm_divider.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit a cycle.
module svpwm_divider #(
	parameter int NW = 56,
	parameter int DW = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic busy,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] n_q;
	logic [DW:0] r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0] rs;
	logic [DW+1:0] diff;
	assign rs = {r_q[DW-1:0], n_q[NW-1]};
	assign diff = {1'b0, rs} - {2'b0, d_q};
	assign busy = (cnt_q != '0);
	assign quo = n_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (start) cnt_q <= CW'(NW);
		else if (busy) cnt_q <= cnt_q - 1'b1;
	end
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num; r_q <= '0; d_q <= den;
		end else if (busy) begin
			if (!diff[DW+1]) begin
				r_q <= diff[DW:0];
				n_q <= {n_q[NW-2:0], 1'b1};
			end else begin
				r_q <= rs;
				n_q <= {n_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

// File: src/svpwm_compare_generator.sv
`timescale 1ns / 1ps
// SVPWM compare generator.
// Input channel (in): vd/vq voltage command, rotor angle, bus voltage, one per beat.
// Output channel (out): three compare values, sector code and overmodulation flag.
// Config: cfg_we/cfg_data write pwm_period; write only while idle.
// Front end: a chain of 16 CORDIC cells, one per rotation, advancing one
// cell a cycle whenever a free slot is ahead; items stream back to back.
// Back end: inverse Park and sector tests, then three divisions of X, Y, Z
// and, on overmodulation, two more, through one shared radix-2 divider
// (each division: start, one shift per quotient bit, result).
// The back end takes one beat at a time; the next beat waits in stage 2
// until it returns to idle, while the cell chain keeps taking beats into free slots.
// Reset sets pwm_period to 4000 and empties the chain and output register.
// A stalled receiver holds the output register; the back end then fills
// and the cell chain backs up to in.ready.
module svpwm_compare_generator #(
	parameter int ANGLE_BITS = svpwm_pkg::ANGLE_BITS_DEF,
	parameter int VOLT_BITS  = svpwm_pkg::VOLT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [15:0] cfg_data,
	svpwm_in_if.sink in,
	svpwm_out_if.source out
);
	import svpwm_pkg::*;
	localparam int VW = VOLT_BITS;
	localparam int PW = 2 * VW + 2 + VW;
	localparam int AW = VW + 3;
	localparam int NW = AW + 36;
	localparam int DW = AW + 19;
	localparam int N  = CORDIC_STEPS;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_DIV  = 3'd1;
	localparam logic [2:0] B_SCL  = 3'd2;
	localparam logic [2:0] B_CMP  = 3'd3;
	localparam logic [2:0] B_OUT  = 3'd4;

	logic [15:0] period_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) period_q <= PERIOD_RESET;
		else if (cfg_we) period_q <= cfg_data;
	end

	// ---- cordic chain
	logic [PH_BITS-1:0] ph, ru;
	logic [1:0] qd;
	logic signed [21:0] z0;
	assign ph = PH_BITS'(in.rotor_angle) << (PH_BITS - ANGLE_BITS);
	assign qd = 2'((ph + PH_BITS'(1 << 17)) >> 18);
	assign ru = ph - {qd, 18'd0};
	assign z0 = ru[19] ? 22'(signed'({2'b11, ru})) : 22'(signed'({2'b00, ru}));

	logic [N:0] vld;
	logic [N:0] en;
	logic signed [17:0] xc [N+1];
	logic signed [17:0] yc [N+1];
	logic signed [21:0] zc [N+1];
	logic [PW-1:0] pl [N+1];
	logic s1_en, s2_en;

	assign vld[0] = in.valid;
	assign xc[0] = 18'sd19898;
	assign yc[0] = '0;
	assign zc[0] = z0;
	assign pl[0] = {in.vd_voltage, in.vq_voltage, qd, in.bus_voltage};
	assign en[N] = s1_en;
	for (genvar i = 0; i < N; i++) begin : g_en
		assign en[i] = en[i+1] || !vld[i+1];
	end
	assign in.ready = en[0];

	for (genvar i = 0; i < N; i++) begin : g_cell
		svpwm_cordic_cell #(.STEP(i), .PW(PW)) u_cell (
			.clk, .arst_n, .en(en[i]), .vld_in(vld[i]),
			.x_in(xc[i]), .y_in(yc[i]), .z_in(zc[i]), .pl_in(pl[i]),
			.vld_q(vld[i+1]), .x_q(xc[i+1]), .y_q(yc[i+1]), .z_q(zc[i+1]),
			.pl_q(pl[i+1])
		);
	end

	// ---- stage 1: quadrant fold and products
	function automatic logic signed [16:0] sat15(input logic signed [17:0] v);
		if (v > 18'sd32767) return 17'sd32767;
		if (v < -18'sd32767) return -17'sd32767;
		return 17'(v);
	endfunction

	logic signed [16:0] xs, ys, cs, sn;
	logic signed [VW-1:0] vd_n, vq_n;
	logic [1:0] q_n;
	logic [VW-1:0] bus_n;
	assign {vd_n, vq_n, q_n, bus_n} = pl[N];
	assign xs = sat15(xc[N]);
	assign ys = sat15(yc[N]);
	always_comb begin
		unique case (q_n)
			2'd0: begin cs = xs;  sn = ys;  end
			2'd1: begin cs = -ys; sn = xs;  end
			2'd2: begin cs = -xs; sn = -ys; end
			default: begin cs = ys; sn = -xs; end
		endcase
	end

	logic s1_v, s2_v;
	logic signed [VW+16:0] dc_s1, qs_s1, ds_s1, qc_s1;
	logic [VW-1:0] bus_s1, bus_s2;
	logic signed [VW+1:0] va_s2, vb_s2;
	logic [2:0] st_q;
	logic s2_take;

	assign s2_take = s2_v && (st_q == B_IDLE);
	assign s2_en = !s2_v || s2_take;
	assign s1_en = !s1_v || s2_en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0; s2_v <= 1'b0;
		end else begin
			if (s1_en) s1_v <= vld[N];
			if (s2_en) s2_v <= s1_v;
		end
	end
	always_ff @(posedge clk) begin
		if (s1_en) begin
			dc_s1 <= vd_n * cs; qs_s1 <= vq_n * sn;
			ds_s1 <= vd_n * sn; qc_s1 <= vq_n * cs;
			bus_s1 <= bus_n;
		end
		if (s2_en) begin
			va_s2 <= (VW+2)'((dc_s1 - qs_s1) >>> 15);
			vb_s2 <= (VW+2)'((ds_s1 + qc_s1) >>> 15);
			bus_s2 <= (bus_s1 == '0) ? VW'(1) : bus_s1;
		end
	end

	// ---- back end sequencer
	logic [2:0] n_q;
	logic signed [AW+17:0] xn_q, yn_q, zn_q;
	logic [VW-1:0] bus_q;
	logic [15:0] t_q;
	logic [1:0] k_q;
	logic signed [AW+17:0] xq_q, yq_q, zq_q;
	logic [AW+17:0] ta_q, tb_q;
	logic ovm_q;
	logic [AW+18:0] sum_q;
	logic started_q;
	logic cur_neg;

	logic [2:0] n_new;
	logic signed [VW+20:0] a3, b3;
	assign a3 = (VW+21)'(va_s2) * (VW+21)'(Q16_SQRT3);
	assign b3 = (VW+21)'(vb_s2) <<< 16;
	assign n_new = {(-a3 - b3) > 0, (a3 - b3) > 0, vb_s2 > 0};

	logic div_start, div_busy;
	logic [NW-1:0] div_num, div_quo;
	logic [DW-1:0] div_den;
	logic signed [AW+17:0] cur_n;
	svpwm_divider #(.NW(NW), .DW(DW)) u_div (
		.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .quo(div_quo)
	);

	always_comb begin
		unique case (k_q)
			2'd0: cur_n = xn_q;
			2'd1: cur_n = yn_q;
			default: cur_n = zn_q;
		endcase
	end
	logic signed [AW+17:0] abs_n;
	assign abs_n = cur_n[AW+17] ? -cur_n : cur_n;
	logic [NW-1:0] absnt;
	assign absnt = NW'(abs_n[AW+16:0]) * NW'(t_q);

	logic signed [AW+17:0] sq;
	assign sq = cur_neg ? -(AW+18)'(div_quo) : (AW+18)'(div_quo);

	logic signed [AW+18:0] ta_c, tb_c;
	always_comb begin
		ta_c = '0; tb_c = '0;
		unique case (n_q)
			3'd3: begin ta_c = yq_q;  tb_c = xq_q;  end
			3'd1: begin ta_c = -yq_q; tb_c = zq_q;  end
			3'd5: begin ta_c = xq_q;  tb_c = -zq_q; end
			3'd4: begin ta_c = -xq_q; tb_c = -yq_q; end
			3'd6: begin ta_c = -zq_q; tb_c = yq_q;  end
			3'd2: begin ta_c = zq_q;  tb_c = -xq_q; end
			default: ;
		endcase
	end
	logic [AW+17:0] ta_p, tb_p;
	assign ta_p = ta_c[AW+18] ? '0 : ta_c[AW+17:0];
	assign tb_p = tb_c[AW+18] ? '0 : tb_c[AW+17:0];
	logic [AW+18:0] tsum;
	assign tsum = ta_p + tb_p;

	logic signed [19:0] v1, v2, v3;
	logic [14:0] c1, c2, c3, lim;
	assign lim = 15'(t_q >> 1);
	assign v1 = (20'(t_q) - 20'(ta_q) - 20'(tb_q)) >>> 2;
	assign v2 = v1 + 20'(ta_q >> 1);
	assign v3 = v2 + 20'(tb_q >> 1);
	function automatic logic [14:0] clampv(input logic signed [19:0] v,
		input logic [14:0] l);
		if (v < 0) return '0;
		if (v > 20'(l)) return l;
		return 15'(v);
	endfunction
	assign c1 = clampv(v1, lim);
	assign c2 = clampv(v2, lim);
	assign c3 = clampv(v3, lim);

	logic o_v_q;
	logic [14:0] oa_q, ob_q, oc_q;
	logic [2:0] on_q;
	logic oo_q;

	always_comb begin
		div_start = (st_q == B_DIV || st_q == B_SCL) && !started_q;
		div_num = absnt;
		div_den = DW'({bus_q, 16'd0});
		if (st_q == B_SCL) begin
			div_num = NW'(k_q == 2'd0 ? ta_q : tb_q) * NW'(t_q);
			div_den = sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE; started_q <= 1'b0; k_q <= 2'd0;
		end else begin
			unique case (st_q)
				B_IDLE: if (s2_v) begin
					st_q <= B_DIV; k_q <= 2'd0;
				end
				B_DIV: if (!started_q) begin
					started_q <= 1'b1;
				end else if (!div_busy) begin
					started_q <= 1'b0;
					if (k_q == 2'd2) begin
						k_q <= 2'd0; st_q <= B_CMP;
					end else k_q <= k_q + 2'd1;
				end
				B_CMP: if (tsum > (AW+19)'(t_q)) st_q <= B_SCL;
					else st_q <= B_OUT;
				B_SCL: if (!started_q) begin
					started_q <= 1'b1;
				end else if (!div_busy) begin
					started_q <= 1'b0;
					k_q <= k_q + 2'd1;
					if (k_q == 2'd1) st_q <= B_OUT;
				end
				B_OUT: if (!o_v_q || out.ready) st_q <= B_IDLE;
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) o_v_q <= 1'b0;
		else if (st_q == B_OUT && (!o_v_q || out.ready)) o_v_q <= 1'b1;
		else if (out.ready) o_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			B_IDLE: if (s2_v) begin
				n_q <= n_new; bus_q <= bus_s2; t_q <= period_q;
				xn_q <= (AW+18)'(vb_s2) * (AW+18)'(Q16_SQRT3);
				yn_q <= (AW+18)'(va_s2) * (AW+18)'(Q16_THREE_HALF)
					- (AW+18)'(vb_s2) * (AW+18)'(Q16_HALF_SQRT3);
				zn_q <= (AW+18)'(va_s2) * (AW+18)'(Q16_THREE_HALF)
					+ (AW+18)'(vb_s2) * (AW+18)'(Q16_HALF_SQRT3);
			end
			B_DIV: if (!started_q) begin
				cur_neg <= cur_n[AW+17];
			end else if (!div_busy) begin
				unique case (k_q)
					2'd0: xq_q <= sq;
					2'd1: yq_q <= sq;
					default: zq_q <= sq;
				endcase
			end
			B_CMP: begin
				ta_q <= ta_p; tb_q <= tb_p; sum_q <= tsum;
				ovm_q <= (tsum > (AW+19)'(t_q));
			end
			B_SCL: if (started_q && !div_busy) begin
				if (k_q == 2'd0) ta_q <= (AW+18)'(div_quo);
				else tb_q <= (AW+18)'(div_quo);
			end
			B_OUT: if (!o_v_q || out.ready) begin
				on_q <= n_q; oo_q <= ovm_q;
				unique case (n_q)
					3'd3: begin oa_q <= c1; ob_q <= c2; oc_q <= c3; end
					3'd1: begin oa_q <= c2; ob_q <= c1; oc_q <= c3; end
					3'd5: begin oa_q <= c3; ob_q <= c1; oc_q <= c2; end
					3'd4: begin oa_q <= c3; ob_q <= c2; oc_q <= c1; end
					3'd6: begin oa_q <= c2; ob_q <= c3; oc_q <= c1; end
					3'd2: begin oa_q <= c1; ob_q <= c3; oc_q <= c2; end
					default: begin oa_q <= c1; ob_q <= c1; oc_q <= c1; end
				endcase
			end
			default: ;
		endcase
	end

	assign out.valid = o_v_q;
	assign out.ccr_a = oa_q;
	assign out.ccr_b = ob_q;
	assign out.ccr_c = oc_q;
	assign out.sector = on_q;
	assign out.overmodulated = oo_q;
endmodule

// File: src/svpwm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module svpwm_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [14:0] ccr_a,
	input logic [14:0] ccr_b,
	input logic [14:0] ccr_c,
	input logic [2:0] sector,
	input logic overmodulated
);
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(ccr_a), "out dropped")
	`ASSERT_IMPL(a_sec, clk, arst_n, out_valid, sector != 3'd7, "bad sector")
	`ASSERT_IMPL(a_zero, clk, arst_n, out_valid && sector == 3'd0, !overmodulated && ccr_a == ccr_b && ccr_b == ccr_c, "zero vector")
endmodule

bind svpwm_compare_generator svpwm_checker u_chk (
	.clk, .arst_n, .out_valid(out.valid), .out_ready(out.ready),
	.ccr_a(out.ccr_a), .ccr_b(out.ccr_b), .ccr_c(out.ccr_c),
	.sector(out.sector), .overmodulated(out.overmodulated)
);

// File: dv/svpwm_compare_checker.sv
`timescale 1ns / 1ps
module svpwm_compare_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [15:0] cfg_data,
	svpwm_in_if.sink in_mon,
	svpwm_out_if.sink out_mon,
	output int errors,
	output int pending
);
	import svpwm_pkg::*;

	typedef struct packed {
		logic [14:0] ca;
		logic [14:0] cb;
		logic [14:0] cc;
		logic [2:0]  sec;
		logic        ovm;
	} pwm_result_t;

	localparam longint ATAN [16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
		652, 326, 163, 81, 41, 20, 10, 5};

	pwm_result_t expected_q[$];
	logic [15:0] period;

	function automatic longint clamp15(longint v);
		if (v > 32767) return 32767;
		if (v < -32767) return -32767;
		return v;
	endfunction

	function automatic pwm_result_t compute_compares(logic signed [15:0] vd_in,
			logic signed [15:0] vq_in, logic [15:0] angle, logic [15:0] bus, logic [15:0] per);
		pwm_result_t r;
		longint vd, vq, udc, t, x, y, z, dx, dy, c, s, va, vb, den, xt, yt, zt, ta, tb;
		longint v1, v2, v3, lim, sum;
		logic [19:0] ph, ru;
		logic [1:0] q;
		int n;
		vd = vd_in;
		vq = vq_in;
		udc = bus;
		t = per;
		ta = 0;
		tb = 0;
		n = 0;
		r.ovm = 1'b0;
		if (udc == 0) udc = 1;
		ph = {angle, 4'b0};
		q = 2'((ph + 20'h20000) >> 18);
		ru = ph - {q, 18'b0};
		z = ru[19] ? longint'(ru) - 1048576 : longint'(ru);
		x = K_INV;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN[i];
			end else begin
				x += dx; y -= dy; z += ATAN[i];
			end
		end
		x = clamp15(x);
		y = clamp15(y);
		case (q)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		va = (vd * c - vq * s) >>> 15;
		vb = (vd * s + vq * c) >>> 15;
		if (vb > 0) n += 1;
		if (Q16_SQRT3 * va - 65536 * vb > 0) n += 2;
		if (-Q16_SQRT3 * va - 65536 * vb > 0) n += 4;
		den = udc * 65536;
		xt = (t * (Q16_SQRT3 * vb)) / den;
		yt = (t * (Q16_THREE_HALF * va - Q16_HALF_SQRT3 * vb)) / den;
		zt = (t * (Q16_THREE_HALF * va + Q16_HALF_SQRT3 * vb)) / den;
		case (n)
			3: begin ta = yt; tb = xt; end
			1: begin ta = -yt; tb = zt; end
			5: begin ta = xt; tb = -zt; end
			4: begin ta = -xt; tb = -yt; end
			6: begin ta = -zt; tb = yt; end
			2: begin ta = zt; tb = -xt; end
			default: ;
		endcase
		if (ta < 0) ta = 0;
		if (tb < 0) tb = 0;
		if (ta + tb > t) begin
			sum = ta + tb;
			ta = (ta * t) / sum;
			tb = (tb * t) / sum;
			r.ovm = 1'b1;
		end
		v1 = (t - ta - tb) / 4;
		v2 = v1 + ta / 2;
		v3 = v2 + tb / 2;
		lim = t / 2;
		if (v1 < 0) v1 = 0;
		if (v1 > lim) v1 = lim;
		if (v2 < 0) v2 = 0;
		if (v2 > lim) v2 = lim;
		if (v3 < 0) v3 = 0;
		if (v3 > lim) v3 = lim;
		case (n)
			3: begin r.ca = 15'(v1); r.cb = 15'(v2); r.cc = 15'(v3); end
			1: begin r.ca = 15'(v2); r.cb = 15'(v1); r.cc = 15'(v3); end
			5: begin r.ca = 15'(v3); r.cb = 15'(v1); r.cc = 15'(v2); end
			4: begin r.ca = 15'(v3); r.cb = 15'(v2); r.cc = 15'(v1); end
			6: begin r.ca = 15'(v2); r.cb = 15'(v3); r.cc = 15'(v1); end
			2: begin r.ca = 15'(v1); r.cb = 15'(v3); r.cc = 15'(v2); end
			default: begin r.ca = 15'(v1); r.cb = 15'(v1); r.cc = 15'(v1); end
		endcase
		r.sec = 3'(n);
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		pwm_result_t got, want;
		if (!arst_n) begin
			period <= PERIOD_RESET;
			errors <= 0;
			expected_q.delete();
		end else begin
			if (cfg_we)
				period <= cfg_data;
			if (in_mon.valid && in_mon.ready)
				expected_q.push_back(compute_compares(in_mon.vd_voltage, in_mon.vq_voltage,
					in_mon.rotor_angle, in_mon.bus_voltage, period));
			if (out_mon.valid && out_mon.ready) begin
				got = '{out_mon.ccr_a, out_mon.ccr_b, out_mon.ccr_c, out_mon.sector,
					out_mon.overmodulated};
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected beat %p", $time, got);
					errors <= errors + 1;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

// File: dv/svpwm_compare_generator_tb.sv
`timescale 1ns / 1ps
module svpwm_compare_generator_tb;
	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [15:0] cfg_data = '0;
	int send_idle_pct, recv_idle_pct;
	int errors, pending, quiet_cycles;

	svpwm_in_if cmd_if ();
	svpwm_out_if cmp_if ();

	svpwm_compare_generator uut (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.cfg_data(cfg_data), .in(cmd_if.sink), .out(cmp_if.source));

	svpwm_compare_checker checker_i (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.cfg_data(cfg_data), .in_mon(cmd_if.sink), .out_mon(cmp_if.sink),
		.errors(errors), .pending(pending));

	always #2 clk = ~clk;

	initial begin
		cmd_if.valid = 0;
		cmd_if.vd_voltage = 0;
		cmd_if.vq_voltage = 0;
		cmd_if.rotor_angle = 0;
		cmd_if.bus_voltage = 1;
		cmp_if.ready = 0;
	end

	always @(posedge clk) begin
		if (!arst_n)
			cmp_if.ready <= 0;
		else
			cmp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_if.valid && cmd_if.ready) || (cmp_if.valid && cmp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_cmd(logic [15:0] vd, logic [15:0] vq, logic [15:0] ang,
			logic [15:0] bus);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_if.valid <= 0;
			@(posedge clk);
		end
		cmd_if.valid <= 1;
		cmd_if.vd_voltage <= vd;
		cmd_if.vq_voltage <= vq;
		cmd_if.rotor_angle <= ang;
		cmd_if.bus_voltage <= bus;
		do @(posedge clk); while (!cmd_if.ready);
	endtask

	task automatic write_period(logic [15:0] p);
		cmd_if.valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		cfg_we <= 1;
		cfg_data <= p;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_random(int count);
		logic [15:0] vd, vq, bus;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0: bus = 16'($urandom_range(65535, 1));
				1: bus = 16'($urandom_range(200, 1));
				default: bus = 16'($urandom_range(4000, 100));
			endcase
			if ($urandom_range(3) == 0) begin
				vd = 16'($urandom);
				vq = 16'($urandom);
			end else begin
				vd = 16'($signed(16'($urandom_range(2 * bus, 0))) - $signed({1'b0, bus}));
				vq = 16'($signed(16'($urandom_range(2 * bus, 0))) - $signed({1'b0, bus}));
			end
			if ($urandom_range(19) == 0)
				bus = 0;
			send_cmd(vd, vq, 16'($urandom), bus);
		end
	endtask

	initial begin
		send_idle_pct = 6;
		recv_idle_pct = 70;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_cmd(16'h0000, 16'h0000, 16'h1234, 16'd100);
		send_cmd(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0001);
		send_cmd(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
		send_cmd(16'h8000, 16'h7FFF, 16'h4000, 16'd1);
		send_cmd(16'h7FFF, 16'h8000, 16'h8000, 16'd0);
		send_cmd(16'd0, 16'd1, 16'h2AAA, 16'd1000);
		send_cmd(16'd0, 16'd1, 16'h5555, 16'd1000);
		for (int k = 0; k < 12; k++)
			send_cmd(16'd500, 16'd300, 16'(k * 5461), 16'd1000);
		write_period(16'd0);
		send_cmd(16'd300, 16'd100, 16'h1000, 16'd600);
		send_cmd(16'h7FFF, 16'h0, 16'h3000, 16'd2);
		write_period(16'hFFFF);
		send_cmd(16'd300, 16'd100, 16'h1000, 16'd600);
		send_cmd(16'h7FFF, 16'h0, 16'h3000, 16'd2);
		send_random(250);
		write_period(16'd1);
		send_idle_pct = 70;
		recv_idle_pct = 6;
		send_random(120);
		write_period(16'($urandom_range(65535, 2)));
		send_random(130);
		write_period(16'd4000);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(250);
		cmd_if.valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// File: files.f
+incdir+src
src/svpwm_pkg.sv
src/svpwm_if.sv
src/svpwm_cordic_cell.sv
src/svpwm_divider.sv
src/svpwm_compare_generator.sv
src/svpwm_checker.sv
dv/svpwm_compare_checker.sv
dv/svpwm_compare_generator_tb.sv
